// File: rtl/i128alu_pkg.sv
// Shared types and opcode constants for the 128-bit integer ALU.
package i128alu_pkg;

  localparam int unsigned WordW = 128;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_MOD = 4'd4,
    OP_AND = 4'd5,
    OP_OR  = 4'd6,
    OP_XOR = 4'd7,
    OP_NOT = 4'd8,
    OP_NEG = 4'd9,
    OP_SHL = 4'd10,
    OP_SHR = 4'd11
  } op_e;

  // What the cell row does for an item.
  typedef enum logic [1:0] {
    KIND_PASS = 2'd0,
    KIND_MUL  = 2'd1,
    KIND_DIV  = 2'd2,
    KIND_MOD  = 2'd3
  } kind_e;

  // Control that travels beside the data through every cell.
  typedef struct packed {
    logic               valid;
    kind_e              kind;
    logic               neg_res;
    logic               eq;
    logic               lt;
    logic               derr;
    logic [WordW-1:0]   simple;
  } tag_t;

  // Working registers of one cell: r is accumulator or partial remainder,
  // s is multiplier or dividend/quotient, d is multiplicand or divisor.
  typedef struct packed {
    logic [WordW-1:0] r;
    logic [WordW-1:0] s;
    logic [WordW-1:0] d;
  } cell_data_t;

endpackage

// File: rtl/i128alu_cell.sv
// One step of the shift-add multiplier and restoring divider chain.
module i128alu_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  i128alu_pkg::tag_t       tag_i,
  input  i128alu_pkg::cell_data_t data_i,
  output i128alu_pkg::tag_t       tag_o,
  output i128alu_pkg::cell_data_t data_o
);
  import i128alu_pkg::*;

  logic       valid_q;
  tag_t       tag_q;
  cell_data_t data_d, data_q;
  logic [WordW-1:0] shifted;
  logic [WordW:0]   diff;

  always_comb begin
    data_d  = data_i;
    shifted = {data_i.r[WordW-2:0], data_i.s[WordW-1]};
    diff    = {data_i.r[WordW-1], shifted} - {1'b0, data_i.d};
    case (tag_i.kind)
      KIND_MUL: begin
        if (data_i.s[0]) begin
          data_d.r = data_i.r + data_i.d;
        end
        data_d.d = {data_i.d[WordW-2:0], 1'b0};
        data_d.s = {1'b0, data_i.s[WordW-1:1]};
      end
      KIND_DIV, KIND_MOD: begin
        // No borrow means the shifted remainder reaches the divisor.
        if (!diff[WordW]) begin
          data_d.r = diff[WordW-1:0];
          data_d.s = {data_i.s[WordW-2:0], 1'b1};
        end else begin
          data_d.r = shifted;
          data_d.s = {data_i.s[WordW-2:0], 1'b0};
        end
      end
      default: begin
        data_d = data_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= tag_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q  <= tag_i;
      data_q <= data_d;
    end
  end

  always_comb begin
    tag_o       = tag_q;
    tag_o.valid = valid_q;
  end
  assign data_o = data_q;

endmodule

// File: rtl/int128_alu.sv
// Top level of the 128-bit integer ALU: operand prep, cell row and output register.
// The ALU takes one item per cycle while the output is not stalled. Operand
// preparation is combinational and is registered at the transfer edge itself.
// Each item then passes through the 128 cells (a cell does one bit of a
// shift-add multiply or of a restoring divide) and through the sign fix-up into
// the output register. All opcodes, simple ones too, take the same path, so
// results leave in order. The whole pipeline holds while a result waits and the
// downstream side is not ready.
module int128_alu (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // op[3:0], a_high[67:4], a_low[131:68], b_high[195:132], b_low[259:196],
  // shift_count[267:260], zero fill above
  input  logic [271:0] s_axis_tdata,
  // is_signed[0]
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // result_high[63:0], result_low[127:64], operands_equal[128],
  // first_less[129], divide_error[130], zero fill above
  output logic [135:0] m_axis_tdata
);
  import i128alu_pkg::*;

  localparam int unsigned NumCells = WordW;

  logic             en;
  op_e              op;
  logic             sgn;
  logic [WordW-1:0] a, b, abs_a, abs_b;
  logic [7:0]       sh;
  logic             an, bn, b_zero;
  tag_t             tag_d;
  cell_data_t       data_d;

  tag_t       tag_w  [0:NumCells];
  cell_data_t data_w [0:NumCells];

  logic             prep_valid_q;
  tag_t             prep_tag_q;
  cell_data_t       prep_data_q;
  logic             out_valid_q;
  logic [135:0]     out_data_d, out_data_q;
  logic [WordW-1:0] fin;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  assign op     = op_e'(s_axis_tdata[3:0]);
  assign sgn    = s_axis_tuser;
  assign a      = {s_axis_tdata[67:4], s_axis_tdata[131:68]};
  assign b      = {s_axis_tdata[195:132], s_axis_tdata[259:196]};
  assign sh     = s_axis_tdata[267:260];
  assign an     = sgn && a[WordW-1];
  assign bn     = sgn && b[WordW-1];
  assign abs_a  = an ? (~a + 1'b1) : a;
  assign abs_b  = bn ? (~b + 1'b1) : b;
  assign b_zero = (b == '0);

  always_comb begin
    tag_d         = '0;
    tag_d.valid   = s_axis_tvalid;
    tag_d.kind    = KIND_PASS;
    tag_d.eq      = (a == b);
    tag_d.lt      = ({a[WordW-1] ^ sgn, a[WordW-2:0]} < {b[WordW-1] ^ sgn, b[WordW-2:0]});
    data_d.r      = '0;
    data_d.s      = b;
    data_d.d      = a;
    case (op)
      OP_ADD: tag_d.simple = a + b;
      OP_SUB: tag_d.simple = a - b;
      OP_MUL: tag_d.kind = KIND_MUL;
      OP_DIV, OP_MOD: begin
        if (b_zero) begin
          tag_d.derr = 1'b1;
        end else begin
          tag_d.kind    = (op == OP_DIV) ? KIND_DIV : KIND_MOD;
          tag_d.neg_res = (op == OP_DIV) ? (an ^ bn) : an;
          data_d.s      = abs_a;
          data_d.d      = abs_b;
        end
      end
      OP_AND: tag_d.simple = a & b;
      OP_OR:  tag_d.simple = a | b;
      OP_XOR: tag_d.simple = a ^ b;
      OP_NOT: tag_d.simple = ~a;
      OP_NEG: tag_d.simple = ~a + 1'b1;
      OP_SHL: tag_d.simple = sh[7] ? '0 : (a << sh[6:0]);
      OP_SHR: begin
        if (sh[7]) begin
          tag_d.simple = sgn ? {WordW{a[WordW-1]}} : '0;
        end else if (sgn) begin
          tag_d.simple = $signed(a) >>> sh[6:0];
        end else begin
          tag_d.simple = a >> sh[6:0];
        end
      end
      default: tag_d.simple = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else if (en) begin
      prep_valid_q <= s_axis_tvalid;
      out_valid_q  <= tag_w[NumCells].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prep_tag_q  <= tag_d;
      prep_data_q <= data_d;
      out_data_q  <= out_data_d;
    end
  end

  always_comb begin
    tag_w[0]       = prep_tag_q;
    tag_w[0].valid = prep_valid_q;
  end
  assign data_w[0] = prep_data_q;

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    i128alu_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .tag_i  (tag_w[i]),
      .data_i (data_w[i]),
      .tag_o  (tag_w[i+1]),
      .data_o (data_w[i+1])
    );
  end

  always_comb begin
    case (tag_w[NumCells].kind)
      KIND_MUL: fin = data_w[NumCells].r;
      KIND_DIV: fin = tag_w[NumCells].neg_res ? (~data_w[NumCells].s + 1'b1)
                                              : data_w[NumCells].s;
      KIND_MOD: fin = tag_w[NumCells].neg_res ? (~data_w[NumCells].r + 1'b1)
                                              : data_w[NumCells].r;
      default:  fin = tag_w[NumCells].simple;
    endcase
    out_data_d = {5'd0, tag_w[NumCells].derr, tag_w[NumCells].lt,
                  tag_w[NumCells].eq, fin[63:0], fin[127:64]};
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
  a_stall_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stall");

  a_derr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[130]) |-> (m_axis_tdata[127:0] == '0))
    else $error("divide error with nonzero result");

  a_eq_not_lt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[128] && m_axis_tdata[129]))
    else $error("equal and less both set");

  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> $stable(out_data_q))
    else $error("stalled result changed");
`endif

endmodule
